FILE: design/bfns_pkg.sv
`default_nettype none

package bfns_pkg;

  localparam int NUM_WORDS = 32;
  localparam int WORD_BITS = 32;
  localparam int WIDX_W    = 5;
  localparam int LEN_W     = 11;
  localparam int POS_W     = 10;
  localparam int CAP_BITS  = NUM_WORDS * WORD_BITS;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_RESIZE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_value;
    logic [LEN_W-1:0]     new_length;
    logic [POS_W-1:0]     start_pos;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] bit_index;
    logic             clamped;
  } out_res_t;

  // Control bundle from the sequencer to the word store.
  typedef struct packed {
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 clr_all;
    logic                 trunc_en;
    logic [WIDX_W:0]      keep_words;
  } store_ctl_t;

  // Bits of word w that lie below the active length len.
  function automatic logic [WORD_BITS-1:0] live_mask(input logic [WIDX_W-1:0] w,
                                                     input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] n;
    base = {1'b0, w, 5'b00000};
    n    = len - base;
    if (len <= base) begin
      live_mask = '0;
    end else if (n >= LEN_W'(WORD_BITS)) begin
      live_mask = '1;
    end else begin
      live_mask = (WORD_BITS'(1) << n[4:0]) - WORD_BITS'(1);
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/bfns_word_store.sv
`default_nettype none

module bfns_word_store (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bfns_pkg::store_ctl_t                ctl,
  output logic      [bfns_pkg::WORD_BITS-1:0]      rd_word
);

  logic [bfns_pkg::WORD_BITS-1:0] mem_r [bfns_pkg::NUM_WORDS];
  logic [bfns_pkg::NUM_WORDS-1:0] vld_r;
  logic [bfns_pkg::NUM_WORDS-1:0] vld_nxt;
  logic [bfns_pkg::WORD_BITS-1:0] rd_data_r;
  logic                           rd_vld_r;

  // A word whose valid bit is clear reads as zero; this gives reset,
  // clear-all and truncation without a clearing pass.
  always_comb begin
    vld_nxt = vld_r;
    if (ctl.clr_all) begin
      vld_nxt = '0;
    end
    if (ctl.trunc_en) begin
      for (int i = 0; i < bfns_pkg::NUM_WORDS; i++) begin
        if ((bfns_pkg::WIDX_W+1)'(i) >= ctl.keep_words) begin
          vld_nxt[i] = 1'b0;
        end
      end
    end
    if (ctl.wr_en) begin
      vld_nxt[ctl.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[ctl.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[ctl.rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: design/bfns_bit_scan.sv
`default_nettype none

module bfns_bit_scan (
  input  wire logic [bfns_pkg::WORD_BITS-1:0] word,
  output logic                                any_set,
  output logic [bfns_pkg::WIDX_W-1:0]         low_pos
);

  // Priority encoder: position of the lowest set bit.
  always_comb begin
    low_pos = '0;
    for (int i = bfns_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        low_pos = bfns_pkg::WIDX_W'(i);
      end
    end
  end

  assign any_set = |word;

endmodule

`default_nettype wire

FILE: design/bitmap_find_next_set.sv
// Bitmap of 32 words of 32 bits with an active length, plus find-next-set.
// Requests arrive on the in_ channel (valid/ready) as one packed struct with
// a command: write word, resize, clear all, or find next set. Each request
// produces exactly one result on the out_ channel (valid/ready).
// The block handles one request at a time; in_ready is low while a request
// is in progress and rises at the same edge at which its result is loaded.
// A write, a clear and a find that starts at or past the length go straight to
// the result stage; a resize does too, or first reads, masks and writes back
// the word in which the new length ends when it ends inside a word. A find that
// scans reads one word per cycle from the word store, starting at the word
// holding start_pos and stopping at the first nonzero word or the last active
// word; the word store has a single read port.
// A request can be accepted while the previous result still waits in the
// output register. If the receiver stalls, the result is held unchanged
// and a finished request waits until the output register is free.
// Reset clears the bitmap through per-word valid bits and the active length
// to zero; no clearing pass is needed.
`default_nettype none

module bitmap_find_next_set (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bfns_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bfns_pkg::out_res_t      out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RSWB = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;

  localparam int WIDX_W = bfns_pkg::WIDX_W;
  localparam int LEN_W  = bfns_pkg::LEN_W;

  logic [2:0]                     state_r, state_nxt;
  logic [LEN_W-1:0]               active_len_r, active_len_nxt;
  logic [WIDX_W-1:0]              scan_w_r, scan_w_nxt;
  logic [WIDX_W-1:0]              last_w_r, last_w_nxt;
  logic [WIDX_W-1:0]              lo_r, lo_nxt;
  logic                           first_r, first_nxt;
  bfns_pkg::out_res_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bfns_pkg::out_res_t             out_r, out_nxt;

  bfns_pkg::store_ctl_t           ctl;
  logic [bfns_pkg::WORD_BITS-1:0] rd_word;
  logic [bfns_pkg::WORD_BITS-1:0] scan_word;
  logic                           scan_hit;
  logic [WIDX_W-1:0]              scan_pos;

  logic                           accept;
  logic                           slot_free;
  logic [LEN_W-1:0]               req_len;
  logic                           req_clamp;
  logic [LEN_W-1:0]               req_len_p;
  logic [LEN_W-1:0]               act_len_p;

  bfns_word_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_word (rd_word)
  );

  // On the first word of a find, bits below start_pos are masked off.
  assign scan_word = first_r ? (rd_word & ('1 << lo_r)) : rd_word;

  bfns_bit_scan u_scan (
    .word    (scan_word),
    .any_set (scan_hit),
    .low_pos (scan_pos)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Resize requests beyond capacity are clamped.
  assign req_clamp = (in_data.new_length > LEN_W'(bfns_pkg::CAP_BITS));
  assign req_len   = req_clamp ? LEN_W'(bfns_pkg::CAP_BITS) : in_data.new_length;
  assign req_len_p = req_len + LEN_W'(31);
  assign act_len_p = active_len_r + LEN_W'(31);

  always_comb begin
    state_nxt      = state_r;
    active_len_nxt = active_len_r;
    scan_w_nxt     = scan_w_r;
    last_w_nxt     = last_w_r;
    lo_nxt         = lo_r;
    first_nxt      = first_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    ctl            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
          case (in_data.cmd)
            bfns_pkg::CMD_WRITE: begin
              ctl.wr_en   = 1'b1;
              ctl.wr_addr = in_data.word_index;
              ctl.wr_data = in_data.word_value &
                            bfns_pkg::live_mask(in_data.word_index, active_len_r);
            end
            bfns_pkg::CMD_RESIZE: begin
              res_nxt.clamped = req_clamp;
              active_len_nxt  = req_len;
              // Words entirely past the new length are dropped at once.
              ctl.trunc_en    = 1'b1;
              ctl.keep_words  = req_len_p[LEN_W-1:5];
              // A length ending inside a word needs that word trimmed.
              if (req_len[4:0] != 5'd0) begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = req_len[9:5];
                scan_w_nxt  = req_len[9:5];
                state_nxt   = ST_RSWB;
              end
            end
            bfns_pkg::CMD_CLEAR: begin
              ctl.clr_all = 1'b1;
            end
            default: begin
              // Find next set bit; a start at or past the length misses.
              if ({1'b0, in_data.start_pos} < active_len_r) begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = in_data.start_pos[9:5];
                scan_w_nxt  = in_data.start_pos[9:5];
                lo_nxt      = in_data.start_pos[4:0];
                last_w_nxt  = WIDX_W'(act_len_p[LEN_W-1:5] - 6'd1);
                first_nxt   = 1'b1;
                state_nxt   = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_RSWB: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = scan_w_r;
        ctl.wr_data = rd_word & bfns_pkg::live_mask(scan_w_r, active_len_r);
        state_nxt   = ST_FIN;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_nxt.found     = 1'b1;
          res_nxt.bit_index = {scan_w_r, scan_pos};
          state_nxt         = ST_FIN;
        end else if (scan_w_r == last_w_r) begin
          state_nxt = ST_FIN;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = scan_w_r + WIDX_W'(1);
          scan_w_nxt  = scan_w_r + WIDX_W'(1);
          first_nxt   = 1'b0;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_len_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_len_r <= active_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r <= scan_w_nxt;
    last_w_r <= last_w_nxt;
    lo_r     <= lo_nxt;
    first_r  <= first_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: design/bfns_checker.sv
`default_nettype none

module bfns_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bfns_pkg::out_res_t out_data
);

  // One request at a time: ready drops right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request was accepted");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // A miss reports index zero.
  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.bit_index == '0))
    else $error("nonzero bit_index without a hit");

  // Only resize sets clamped, only find sets found.
  a_found_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.clamped))
    else $error("found and clamped both set");

endmodule

bind bitmap_find_next_set bfns_checker u_bfns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
